// ===== sv/assert_macros.svh =====
// Assertion macros used by the tracker RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define FRT_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");

// Condition must never be true outside reset.
`define FRT_ASSERT_NEVER(lbl, clk, rst, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("forbidden condition seen");

`endif

// ===== sv/frt_pkg.sv =====
`default_nettype none
package frt_pkg;

   localparam int DEF_MAX_FRAGMENTS = 256;
   localparam int DEF_FRAGMENT_SIZE = 128;
   localparam logic [31:0] CRC_POLY = 32'hEDB88320;
   localparam logic [5:0] REPLY_MAX = 6'd32;
   localparam logic [5:0] LIMIT_RESET = 6'd32;

   typedef enum logic [2:0] {
      KIND_HEADER  = 3'd0,
      KIND_DATA    = 3'd1,
      KIND_RESTART = 3'd2,
      KIND_BITMAP  = 3'd3,
      KIND_CRC     = 3'd4
   } kind_type;

   typedef enum logic [2:0] {
      STS_OK         = 3'd0,
      STS_DUP        = 3'd1,
      STS_RANGE      = 3'd2,
      STS_LENGTH     = 3'd3,
      STS_TOO_MANY   = 3'd4,
      STS_NO_SESSION = 3'd5
   } status_type;

   typedef enum logic [4:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_HDR_SES,
      ST_HDR_CHK,
      ST_HDR_RD,
      ST_BM_SCAN_RD,
      ST_BM_SCAN_CHK,
      ST_BM_SIZE,
      ST_BM_RD0,
      ST_BM_LD0,
      ST_BM_RD,
      ST_BM_EMIT,
      ST_CRC_LEN,
      ST_CRC_LWAIT,
      ST_CRC_RD,
      ST_CRC_UPD,
      ST_RESP
   } state_type;

   // Reflected CRC-32 advanced by one byte.
   function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] data);
      logic [31:0] c;
      c = crc ^ {24'd0, data};
      for (int b = 0; b < 8; b++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

endpackage
`default_nettype wire

// ===== sv/frt_crc_unit.sv =====
`default_nettype none
module frt_crc_unit (
   input  wire logic        clock,
   input  wire logic        init,
   input  wire logic        upd,
   input  wire logic [7:0]  data,
   output logic      [31:0] crc
);
   import frt_pkg::*;

   logic [31:0] crc_ff;
   logic [31:0] crc_in;

   always_comb begin
      crc_in = crc_ff;
      if (init) begin
         crc_in = 32'hFFFFFFFF;
      end else if (upd) begin
         crc_in = crc_byte(crc_ff, data);
      end
   end

   always_ff @(posedge clock) begin
      crc_ff <= crc_in;
   end

   assign crc = crc_ff;

endmodule
`default_nettype wire

// ===== sv/fragment_reassembly_tracker.sv =====
// Payload beats are stored one per cycle while the tracker is idle. A header is checked
// against the session, clears the map when it opens one, is checked for range and length,
// reads its flag row and holds the input until its reply is taken. A bitmap request scans
// the map one row of 8 fragments at a time, then emits one byte per reply beat; a CRC request
// reads each fragment's length, then its stored bytes one at a time. One item is worked on at
// a time, as the input is ready only when idle. Synchronous reset; the flag map is then cleared.
`default_nettype none
`include "assert_macros.svh"
module fragment_reassembly_tracker #(
   parameter int MAX_FRAGMENTS = frt_pkg::DEF_MAX_FRAGMENTS,
   parameter int FRAGMENT_SIZE = frt_pkg::DEF_FRAGMENT_SIZE
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // session_tag, fragment_number, fragment_total, fragment_length, payload_byte
   input  wire logic [71:0] req_tdata,
   // kind
   input  wire logic [2:0]  req_tuser,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // status, complete, received_count, total_bytes, gap_index, byte_count,
   // bitmap_byte, crc_value, zero padding
   output logic [87:0]      rsp_tdata,
   output logic             rsp_tlast,
   input  wire logic        csr_wr_en,
   input  wire logic [5:0]  csr_wr_data
);
   import frt_pkg::*;

   localparam int STORE_DEPTH = MAX_FRAGMENTS * FRAGMENT_SIZE;
   localparam int SAW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
   localparam int FIW = (MAX_FRAGMENTS > 8) ? $clog2(MAX_FRAGMENTS) : 3;
   localparam int TW = $clog2(MAX_FRAGMENTS + 1);
   localparam int ROWS = (MAX_FRAGMENTS + 7) / 8;
   localparam int RW = (ROWS > 1) ? $clog2(ROWS) : 1;
   localparam int RCW = $clog2(ROWS + 40);

   // Memories
   logic [7:0] pay_mem [STORE_DEPTH];
   logic [7:0] len_mem [MAX_FRAGMENTS];
   logic [7:0] flag_mem [ROWS];

   logic [7:0] pay_rd_ff, len_rd_ff, flag_rd_ff;
   logic pay_we, pay_re, len_we, len_re, flag_we, flag_re;
   logic [SAW-1:0] pay_raddr;
   logic [RW-1:0] flag_addr;
   logic [7:0] flag_wdata;

   // Control state
   state_type state_ff, state_in;
   logic active_ff, active_in;
   logic [15:0] session_ff, session_in;
   logic [TW-1:0] total_ff, total_in;
   logic [TW-1:0] got_ff, got_in;
   logic [15:0] sum_ff, sum_in;
   logic [SAW-1:0] wp_ff, wp_in;
   logic [7:0] left_ff, left_in;
   logic [5:0] limit_ff, limit_in;
   logic [RCW-1:0] row_ff, row_in;
   logic clr_hdr_ff, clr_hdr_in;
   logic more_ff, more_in;
   logic rsp_valid_ff, rsp_valid_in;

   // Working registers
   logic [15:0] tag_ff, tag_in, idx_ff, idx_in, tot_ff, tot_in, len_ff, len_in;
   logic [FIW-1:0] first_ff, first_in;
   logic [5:0] nb_ff, nb_in, k_ff, k_in;
   logic [7:0] lo_ff, lo_in;
   logic rd_ok_ff, rd_ok_in;
   logic [TW-1:0] frag_ff, frag_in;
   logic [SAW-1:0] base_ff, base_in;
   logic [7:0] j_ff, j_in, n_ff, n_in;

   // Result register
   status_type status_ff, status_in;
   logic [7:0] fm_ff, fm_in, bb_ff, bb_in;
   logic [5:0] bc_ff, bc_in;
   logic [31:0] crco_ff, crco_in;
   logic last_ff, last_in;

   logic crc_init, crc_upd;
   logic [31:0] crc_val;

   frt_crc_unit u_crc (
      .clock (clock),
      .init  (crc_init),
      .upd   (crc_upd),
      .data  (pay_rd_ff),
      .crc   (crc_val)
   );

   // Shared decisions
   logic acc_w, rsp_done_w, complete_w, no_ses_w, new_ses_w, too_many_w;
   logic idx_bad_w, len_bad_w, dup_w, found_w, scan_end_w;
   logic [7:0] vmask_w, miss_w;
   logic [2:0] low_w;
   logic [16:0] rem_w, q_w;
   logic [5:0] lim_w, nb_w;
   logic [15:0] bm_pair_w;
   kind_type kind_w;

   assign acc_w = req_tvalid && req_tready;
   assign rsp_done_w = rsp_valid_ff && rsp_tready;
   assign kind_w = kind_type'(req_tuser);
   assign complete_w = active_ff && (total_ff != '0) && (got_ff == total_ff);
   assign no_ses_w = !active_ff || (total_ff == '0);
   assign new_ses_w = !active_ff || (tag_ff != session_ff);
   assign too_many_w = 17'(tot_ff) > 17'(MAX_FRAGMENTS);
   assign idx_bad_w = (17'(idx_ff) >= 17'(total_ff)) || (17'(idx_ff) >= 17'(MAX_FRAGMENTS));
   assign len_bad_w = 17'(len_ff) > 17'(FRAGMENT_SIZE);
   assign dup_w = flag_rd_ff[idx_ff[2:0]];

   always_comb begin
      for (int i = 0; i < 8; i++) begin
         vmask_w[i] = ((17'(row_ff) << 3) + 17'(i)) < 17'(total_ff);
      end
      miss_w = ~flag_rd_ff & vmask_w;
      low_w = 3'd0;
      for (int i = 7; i >= 0; i--) begin
         if (miss_w[i]) begin
            low_w = 3'(i);
         end
      end
   end

   assign found_w = |miss_w;
   assign scan_end_w = ((17'(row_ff) + 17'd1) << 3) >= 17'(total_ff);
   assign rem_w = 17'(total_ff) - 17'(first_ff);
   assign q_w = (rem_w + 17'd7) >> 3;
   assign lim_w = (limit_ff > REPLY_MAX) ? REPLY_MAX : limit_ff;
   assign nb_w = (q_w > 17'(lim_w)) ? lim_w : 6'(q_w);
   assign bm_pair_w = {(rd_ok_ff ? flag_rd_ff : 8'd0), lo_ff} >> first_ff[2:0];

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (row_ff == RCW'(ROWS - 1)) begin
               state_in = clr_hdr_ff ? ST_HDR_CHK : ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (acc_w) begin
               case (kind_w)
                  KIND_HEADER: state_in = ST_HDR_SES;
                  KIND_RESTART: begin
                     if (!no_ses_w) begin
                        state_in = ST_CLEAR;
                     end
                  end
                  KIND_BITMAP: state_in = no_ses_w ? ST_RESP : ST_BM_SCAN_RD;
                  KIND_CRC: state_in = (no_ses_w || !complete_w) ? ST_RESP : ST_CRC_LEN;
                  default: state_in = ST_IDLE;
               endcase
            end
         end
         ST_HDR_SES: begin
            if (new_ses_w) begin
               state_in = too_many_w ? ST_RESP : ST_CLEAR;
            end else begin
               state_in = ST_HDR_CHK;
            end
         end
         ST_HDR_CHK: state_in = (idx_bad_w || len_bad_w) ? ST_RESP : ST_HDR_RD;
         ST_HDR_RD: state_in = ST_RESP;
         ST_BM_SCAN_RD: state_in = ST_BM_SCAN_CHK;
         ST_BM_SCAN_CHK: begin
            if (found_w) begin
               state_in = ST_BM_SIZE;
            end else if (scan_end_w) begin
               state_in = ST_RESP;
            end else begin
               state_in = ST_BM_SCAN_RD;
            end
         end
         ST_BM_SIZE: state_in = (nb_w == 6'd0) ? ST_RESP : ST_BM_RD0;
         ST_BM_RD0: state_in = ST_BM_LD0;
         ST_BM_LD0: state_in = ST_BM_RD;
         ST_BM_RD: state_in = ST_BM_EMIT;
         ST_BM_EMIT: state_in = ST_RESP;
         ST_CRC_LEN: state_in = (frag_ff >= total_ff) ? ST_RESP : ST_CRC_LWAIT;
         ST_CRC_LWAIT: state_in = ST_CRC_RD;
         ST_CRC_RD: state_in = (j_ff == n_ff) ? ST_CRC_LEN : ST_CRC_UPD;
         ST_CRC_UPD: state_in = ST_CRC_RD;
         ST_RESP: begin
            if (rsp_done_w) begin
               state_in = more_ff ? ST_BM_RD : ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Datapath, memory controls and result loading
   always_comb begin
      logic load;
      status_type ld_status;
      logic [7:0] ld_fm, ld_bb;
      logic [5:0] ld_bc;
      logic [31:0] ld_crc;
      logic ld_last, ld_more;

      load = 1'b0;
      ld_status = STS_OK;
      ld_fm = 8'd0;
      ld_bb = 8'd0;
      ld_bc = 6'd0;
      ld_crc = 32'd0;
      ld_last = 1'b1;
      ld_more = 1'b0;

      active_in = active_ff;
      session_in = session_ff;
      total_in = total_ff;
      got_in = got_ff;
      sum_in = sum_ff;
      wp_in = wp_ff;
      left_in = left_ff;
      limit_in = csr_wr_en ? csr_wr_data : limit_ff;
      row_in = row_ff;
      clr_hdr_in = clr_hdr_ff;
      more_in = more_ff;
      rsp_valid_in = rsp_valid_ff;
      tag_in = tag_ff;
      idx_in = idx_ff;
      tot_in = tot_ff;
      len_in = len_ff;
      first_in = first_ff;
      nb_in = nb_ff;
      k_in = k_ff;
      lo_in = lo_ff;
      rd_ok_in = rd_ok_ff;
      frag_in = frag_ff;
      base_in = base_ff;
      j_in = j_ff;
      n_in = n_ff;
      status_in = status_ff;
      fm_in = fm_ff;
      bb_in = bb_ff;
      bc_in = bc_ff;
      crco_in = crco_ff;
      last_in = last_ff;

      pay_we = 1'b0;
      pay_re = 1'b0;
      pay_raddr = base_ff + SAW'(j_ff);
      len_we = 1'b0;
      len_re = 1'b0;
      flag_we = 1'b0;
      flag_re = 1'b0;
      flag_addr = RW'(row_ff);
      flag_wdata = 8'd0;
      crc_init = 1'b0;
      crc_upd = 1'b0;

      if (rsp_done_w) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_CLEAR: begin
            flag_we = 1'b1;
            row_in = row_ff + RCW'(1);
         end
         ST_IDLE: begin
            if (acc_w) begin
               tag_in = req_tdata[15:0];
               idx_in = req_tdata[31:16];
               tot_in = req_tdata[47:32];
               len_in = req_tdata[63:48];
               case (kind_w)
                  KIND_DATA: begin
                     if (left_ff != 8'd0) begin
                        pay_we = 1'b1;
                        wp_in = wp_ff + SAW'(1);
                        left_in = left_ff - 8'd1;
                     end
                  end
                  KIND_RESTART: begin
                     if (!no_ses_w) begin
                        got_in = '0;
                        sum_in = 16'd0;
                        left_in = 8'd0;
                        row_in = '0;
                        clr_hdr_in = 1'b0;
                     end
                  end
                  KIND_BITMAP: begin
                     row_in = '0;
                     if (no_ses_w) begin
                        load = 1'b1;
                        ld_status = STS_NO_SESSION;
                     end
                  end
                  KIND_CRC: begin
                     frag_in = '0;
                     base_in = '0;
                     crc_init = 1'b1;
                     if (no_ses_w) begin
                        load = 1'b1;
                        ld_status = STS_NO_SESSION;
                     end else if (!complete_w) begin
                        load = 1'b1;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_HDR_SES: begin
            if (new_ses_w) begin
               got_in = '0;
               sum_in = 16'd0;
               left_in = 8'd0;
               if (too_many_w) begin
                  active_in = 1'b0;
                  session_in = 16'd0;
                  total_in = '0;
                  load = 1'b1;
                  ld_status = STS_TOO_MANY;
               end else begin
                  active_in = 1'b1;
                  session_in = tag_ff;
                  total_in = TW'(tot_ff);
                  row_in = '0;
                  clr_hdr_in = 1'b1;
               end
            end
         end
         ST_HDR_CHK: begin
            left_in = 8'd0;
            if (idx_bad_w) begin
               load = 1'b1;
               ld_status = STS_RANGE;
            end else if (len_bad_w) begin
               load = 1'b1;
               ld_status = STS_LENGTH;
            end else begin
               flag_re = 1'b1;
               flag_addr = RW'(idx_ff >> 3);
            end
         end
         ST_HDR_RD: begin
            load = 1'b1;
            if (dup_w) begin
               ld_status = STS_DUP;
            end else begin
               flag_we = 1'b1;
               flag_addr = RW'(idx_ff >> 3);
               flag_wdata = flag_rd_ff | (8'd1 << idx_ff[2:0]);
               len_we = 1'b1;
               got_in = got_ff + TW'(1);
               sum_in = sum_ff + len_ff;
               wp_in = SAW'(idx_ff) * SAW'(FRAGMENT_SIZE);
               left_in = len_ff[7:0];
            end
         end
         ST_BM_SCAN_RD: begin
            flag_re = 1'b1;
         end
         ST_BM_SCAN_CHK: begin
            if (found_w) begin
               first_in = FIW'((17'(row_ff) << 3) + 17'(low_w));
            end else if (scan_end_w) begin
               load = 1'b1;
            end else begin
               row_in = row_ff + RCW'(1);
            end
         end
         ST_BM_SIZE: begin
            nb_in = nb_w;
            k_in = 6'd0;
            row_in = RCW'(first_ff >> 3);
            if (nb_w == 6'd0) begin
               load = 1'b1;
               ld_fm = 8'(first_ff);
            end
         end
         ST_BM_RD0: begin
            flag_re = 1'b1;
         end
         ST_BM_LD0: begin
            lo_in = flag_rd_ff;
            row_in = row_ff + RCW'(1);
         end
         ST_BM_RD: begin
            rd_ok_in = 17'(row_ff) < 17'(ROWS);
            flag_re = 17'(row_ff) < 17'(ROWS);
         end
         ST_BM_EMIT: begin
            load = 1'b1;
            ld_fm = 8'(first_ff);
            ld_bc = nb_ff;
            ld_bb = bm_pair_w[7:0];
            ld_last = (k_ff + 6'd1) == nb_ff;
            ld_more = (k_ff + 6'd1) != nb_ff;
            lo_in = rd_ok_ff ? flag_rd_ff : 8'd0;
            k_in = k_ff + 6'd1;
            row_in = row_ff + RCW'(1);
         end
         ST_CRC_LEN: begin
            if (frag_ff >= total_ff) begin
               load = 1'b1;
               ld_crc = ~crc_val;
            end else begin
               len_re = 1'b1;
            end
         end
         ST_CRC_LWAIT: begin
            n_in = len_rd_ff;
            j_in = 8'd0;
         end
         ST_CRC_RD: begin
            if (j_ff == n_ff) begin
               frag_in = frag_ff + TW'(1);
               base_in = base_ff + SAW'(FRAGMENT_SIZE);
            end else begin
               pay_re = 1'b1;
            end
         end
         ST_CRC_UPD: begin
            crc_upd = 1'b1;
            j_in = j_ff + 8'd1;
         end
         ST_RESP: begin
         end
         default: begin
         end
      endcase

      if (load) begin
         rsp_valid_in = 1'b1;
         status_in = ld_status;
         fm_in = ld_fm;
         bc_in = ld_bc;
         bb_in = ld_bb;
         crco_in = ld_crc;
         last_in = ld_last;
         more_in = ld_more;
      end
   end

   // Memories
   always_ff @(posedge clock) begin
      if (pay_we) begin
         pay_mem[wp_ff] <= req_tdata[71:64];
      end
      if (pay_re) begin
         pay_rd_ff <= pay_mem[pay_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (len_we) begin
         len_mem[FIW'(idx_ff)] <= len_ff[7:0];
      end
      if (len_re) begin
         len_rd_ff <= len_mem[FIW'(frag_ff)];
      end
   end

   always_ff @(posedge clock) begin
      if (flag_we) begin
         flag_mem[flag_addr] <= flag_wdata;
      end
      if (flag_re) begin
         flag_rd_ff <= flag_mem[flag_addr];
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         active_ff <= 1'b0;
         session_ff <= 16'd0;
         total_ff <= '0;
         got_ff <= '0;
         sum_ff <= 16'd0;
         wp_ff <= '0;
         left_ff <= 8'd0;
         limit_ff <= LIMIT_RESET;
         row_ff <= '0;
         clr_hdr_ff <= 1'b0;
         more_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         active_ff <= active_in;
         session_ff <= session_in;
         total_ff <= total_in;
         got_ff <= got_in;
         sum_ff <= sum_in;
         wp_ff <= wp_in;
         left_ff <= left_in;
         limit_ff <= limit_in;
         row_ff <= row_in;
         clr_hdr_ff <= clr_hdr_in;
         more_ff <= more_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Working and result registers, not reset
   always_ff @(posedge clock) begin
      tag_ff <= tag_in;
      idx_ff <= idx_in;
      tot_ff <= tot_in;
      len_ff <= len_in;
      first_ff <= first_in;
      nb_ff <= nb_in;
      k_ff <= k_in;
      lo_ff <= lo_in;
      rd_ok_ff <= rd_ok_in;
      frag_ff <= frag_in;
      base_ff <= base_in;
      j_ff <= j_in;
      n_ff <= n_in;
      status_ff <= status_in;
      fm_ff <= fm_in;
      bb_ff <= bb_in;
      bc_ff <= bc_in;
      crco_ff <= crco_in;
      last_ff <= last_in;
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tlast = last_ff;
   assign rsp_tdata = {5'd0, crco_ff, bb_ff, bc_ff, fm_ff, sum_ff, 9'(got_ff),
                       complete_w, status_ff};

   `FRT_ASSERT_NEVER(a_ready_while_result, clock, reset, req_tready && rsp_tvalid)
   `FRT_ASSERT(a_count_bounded, clock, reset, got_ff <= total_ff)
   `FRT_ASSERT(a_pending_needs_session, clock, reset, (left_ff != 8'd0) |-> active_ff)

endmodule
`default_nettype wire

// ===== sim/fragment_reassembly_tracker_tb.sv =====
`default_nettype none
module fragment_reassembly_tracker_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import frt_pkg::*;

   localparam int FRAGS = DEF_MAX_FRAGMENTS;
   localparam int FSIZE = DEF_FRAGMENT_SIZE;
   localparam int DEPTH = FRAGS * FSIZE;

   typedef struct {
      logic [2:0]  status;
      logic        complete;
      logic [8:0]  received_count;
      logic [15:0] total_bytes;
      logic [7:0]  gap_index;
      logic [5:0]  byte_count;
      logic [7:0]  bitmap_byte;
      logic [31:0] crc_value;
      logic        last;
   } reply_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [71:0] req_tdata = '0;
   logic [2:0]  req_tuser = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [87:0] rsp_tdata;
   logic        rsp_tlast;
   logic        csr_wr_en = 1'b0;
   logic [5:0]  csr_wr_data = '0;

   fragment_reassembly_tracker uut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tlast(rsp_tlast),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Tracker state as the block should hold it.
   logic [7:0]  payload_mem [DEPTH];
   bit          payload_written [DEPTH];
   logic [7:0]  frag_len [FRAGS];
   bit          frag_seen [FRAGS];
   bit          session_open;
   logic [15:0] session_tag;
   int          frag_total;
   int          frags_got;
   logic [15:0] bytes_sum;
   int          store_ptr;
   int          bytes_pending;
   logic [5:0]  bitmap_limit;

   reply_type   pending_replies[$];
   int          fail_count;
   int          items_sent;
   int          replies_seen;
   int          limit_writes;
   int          send_idle_pct;
   int          recv_idle_pct;

   function automatic bit tracker_complete();
      return session_open && frag_total != 0 && frags_got == frag_total;
   endfunction

   function automatic void push_reply(logic [2:0] status, logic [7:0] fm, logic [5:0] bc,
                                      logic [7:0] bb, logic [31:0] crc, logic last);
      reply_type r;
      r.status = status;
      r.complete = tracker_complete();
      r.received_count = 9'(frags_got);
      r.total_bytes = bytes_sum;
      r.gap_index = fm;
      r.byte_count = bc;
      r.bitmap_byte = bb;
      r.crc_value = crc;
      r.last = last;
      pending_replies.push_back(r);
   endfunction

   function automatic logic [31:0] payload_crc();
      logic [31:0] c;
      c = 32'hFFFF_FFFF;
      for (int f = 0; f < frag_total && f < FRAGS; f++) begin
         for (int j = 0; j < frag_len[f]; j++) begin
            c = c ^ {24'd0, payload_mem[f * FSIZE + j]};
            for (int b = 0; b < 8; b++) begin
               c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
            end
         end
      end
      return ~c;
   endfunction

   // A CRC over a complete session must only touch bytes that were stored at some point.
   function automatic bit crc_reads_known_bytes();
      if (!tracker_complete()) begin
         return 1'b1;
      end
      for (int f = 0; f < frag_total; f++) begin
         for (int j = 0; j < frag_len[f]; j++) begin
            if (!payload_written[f * FSIZE + j]) begin
               return 1'b0;
            end
         end
      end
      return 1'b1;
   endfunction

   function automatic void close_tracker();
      session_open = 1'b0;
      session_tag = '0;
      frag_total = 0;
      frags_got = 0;
      bytes_sum = '0;
      bytes_pending = 0;
   endfunction

   function automatic void apply_header(logic [15:0] tag, logic [15:0] idx, logic [15:0] tot,
                                        logic [15:0] len);
      if (!session_open || tag != session_tag) begin
         close_tracker();
         if (tot > FRAGS) begin
            push_reply(STS_TOO_MANY, 0, 0, 0, 0, 1'b1);
            return;
         end
         for (int i = 0; i < FRAGS; i++) begin
            frag_seen[i] = 1'b0;
         end
         session_open = 1'b1;
         session_tag = tag;
         frag_total = tot;
      end
      bytes_pending = 0;
      if (idx >= frag_total || idx >= FRAGS) begin
         push_reply(STS_RANGE, 0, 0, 0, 0, 1'b1);
      end else if (len > FSIZE) begin
         push_reply(STS_LENGTH, 0, 0, 0, 0, 1'b1);
      end else if (frag_seen[idx]) begin
         push_reply(STS_DUP, 0, 0, 0, 0, 1'b1);
      end else begin
         frag_seen[idx] = 1'b1;
         frags_got++;
         bytes_sum = bytes_sum + len;
         frag_len[idx] = len[7:0];
         store_ptr = idx * FSIZE;
         bytes_pending = len;
         push_reply(STS_OK, 0, 0, 0, 0, 1'b1);
      end
   endfunction

   function automatic void apply_bitmap();
      int first;
      int nbytes;
      int lim;
      logic [7:0] v;
      if (!session_open || frag_total == 0) begin
         push_reply(STS_NO_SESSION, 0, 0, 0, 0, 1'b1);
         return;
      end
      first = frag_total;
      for (int i = 0; i < frag_total; i++) begin
         if (!frag_seen[i]) begin
            first = i;
            break;
         end
      end
      if (first >= frag_total) begin
         push_reply(STS_OK, 0, 0, 0, 0, 1'b1);
         return;
      end
      nbytes = (frag_total - first + 7) / 8;
      lim = (bitmap_limit > REPLY_MAX) ? int'(REPLY_MAX) : int'(bitmap_limit);
      if (nbytes > lim) begin
         nbytes = lim;
      end
      if (nbytes == 0) begin
         push_reply(STS_OK, 8'(first), 0, 0, 0, 1'b1);
         return;
      end
      for (int k = 0; k < nbytes; k++) begin
         v = '0;
         for (int b = 0; b < 8; b++) begin
            if (first + k * 8 + b < frag_total && frag_seen[first + k * 8 + b]) begin
               v[b] = 1'b1;
            end
         end
         push_reply(STS_OK, 8'(first), 6'(nbytes), v, 0, k + 1 == nbytes);
      end
   endfunction

   function automatic void apply_item(logic [2:0] kind, logic [71:0] data);
      case (kind)
         KIND_HEADER: begin
            apply_header(data[15:0], data[31:16], data[47:32], data[63:48]);
         end
         KIND_DATA: begin
            if (bytes_pending != 0) begin
               payload_mem[store_ptr] = data[71:64];
               payload_written[store_ptr] = 1'b1;
               store_ptr++;
               bytes_pending--;
            end
         end
         KIND_RESTART: begin
            if (session_open && frag_total != 0) begin
               for (int i = 0; i < FRAGS; i++) begin
                  frag_seen[i] = 1'b0;
               end
               frags_got = 0;
               bytes_sum = '0;
               bytes_pending = 0;
            end
         end
         KIND_BITMAP: begin
            apply_bitmap();
         end
         KIND_CRC: begin
            if (!session_open || frag_total == 0) begin
               push_reply(STS_NO_SESSION, 0, 0, 0, 0, 1'b1);
            end else begin
               push_reply(STS_OK, 0, 0, 0, tracker_complete() ? payload_crc() : 32'd0, 1'b1);
            end
         end
         default: begin
         end
      endcase
   endfunction

   // Sends one beat; valid stays high afterwards unless the next call idles first.
   task automatic send_item(logic [2:0] kind, logic [15:0] tag, logic [15:0] num,
                            logic [15:0] tot, logic [15:0] len, logic [7:0] pb);
      if (kind == KIND_CRC && !crc_reads_known_bytes()) begin
         kind = KIND_BITMAP;
      end
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= kind;
      req_tdata <= {pb, len, tot, num, tag};
      do @(posedge clock); while (!req_tready);
      apply_item(kind, {pb, len, tot, num, tag});
      items_sent++;
   endtask

   task automatic send_header(logic [15:0] tag, logic [15:0] num, logic [15:0] tot,
                              logic [15:0] len);
      send_item(KIND_HEADER, tag, num, tot, len, 8'($urandom));
   endtask

   task automatic send_request(logic [2:0] kind);
      send_item(kind, 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                8'($urandom));
   endtask

   task automatic send_bytes(int n);
      for (int i = 0; i < n; i++) begin
         send_item(KIND_DATA, 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                   8'($urandom));
      end
   endtask

   // Waits for every reply, then lets a header's clearing pass finish.
   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_replies.size() != 0) begin
         @(posedge clock);
      end
      repeat (80) @(posedge clock);
   endtask

   task automatic write_limit(logic [5:0] value);
      drain();
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      bitmap_limit = value;
      limit_writes++;
   endtask

   always @(posedge clock) begin
      reply_type got;
      reply_type want;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            got.status = rsp_tdata[2:0];
            got.complete = rsp_tdata[3];
            got.received_count = rsp_tdata[12:4];
            got.total_bytes = rsp_tdata[28:13];
            got.gap_index = rsp_tdata[36:29];
            got.byte_count = rsp_tdata[42:37];
            got.bitmap_byte = rsp_tdata[50:43];
            got.crc_value = rsp_tdata[82:51];
            got.last = rsp_tlast;
            replies_seen++;
            if (pending_replies.size() == 0) begin
               $display("%0t: unexpected reply beat %p", $time, got);
               fail_count++;
            end else begin
               want = pending_replies.pop_front();
               if (got.status !== want.status || got.complete !== want.complete
                   || got.received_count !== want.received_count
                   || got.total_bytes !== want.total_bytes
                   || got.gap_index !== want.gap_index
                   || got.byte_count !== want.byte_count
                   || got.bitmap_byte !== want.bitmap_byte
                   || got.crc_value !== want.crc_value || got.last !== want.last) begin
                  $display("%0t: reply mismatch\n  expected %p\n  actual   %p",
                           $time, want, got);
                  fail_count++;
               end
            end
         end
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   task automatic test_header_cases();
      send_request(KIND_CRC);
      send_request(KIND_BITMAP);
      send_header(16'hFFFF, 0, 16'd257, 1);
      send_header(16'h00A5, 16'hFFFF, 4, 1);
      send_header(16'h00A5, 0, 4, 16'hFFFF);
      send_header(16'h00A5, 0, 4, 3);
      send_item(KIND_DATA, 0, 0, 0, 0, 8'h00);
      send_item(KIND_DATA, 0, 0, 0, 0, 8'hFF);
      send_bytes(2);
      send_header(16'h00A5, 0, 4, 2);
      send_bytes(1);
      send_request(KIND_BITMAP);
      send_header(16'h00A5, 1, 9, 0);
      send_header(16'h00A5, 2, 0, 1);
      send_bytes(1);
      send_header(16'h00A5, 3, 0, 1);
      send_bytes(1);
      send_request(KIND_CRC);
      send_item(3'd7, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF);
      send_request(KIND_RESTART);
      send_request(KIND_BITMAP);
      send_header(16'h0000, 0, 0, 0);
      send_request(KIND_RESTART);
      send_request(KIND_CRC);
   endtask

   task automatic test_bitmap_limits();
      send_header(16'h1234, 0, 16'd256, 0);
      send_header(16'h1234, 1, 16'd256, 0);
      send_header(16'h1234, 5, 16'd256, 0);
      send_header(16'h1234, 255, 16'd256, 0);
      send_request(KIND_BITMAP);
      write_limit(6'd0);
      send_request(KIND_BITMAP);
      write_limit(6'd1);
      send_request(KIND_BITMAP);
      write_limit(6'd63);
      send_request(KIND_BITMAP);
      write_limit(6'd32);
   endtask

   // One transfer: headers in shuffled order, each followed by its payload beats.
   task automatic run_session(bit pause_midway);
      logic [15:0] tag;
      int tot;
      int sent_frags;
      int order[$];
      int len;
      int pick;
      tag = 16'($urandom);
      pick = $urandom_range(99);
      tot = (pick < 70) ? $urandom_range(1, 8) : (pick < 85) ? $urandom_range(9, 40)
          : (pick < 90) ? FRAGS : (pick < 95) ? 0 : $urandom_range(FRAGS + 1, 65535);
      sent_frags = (tot > 12) ? $urandom_range(1, 12) : tot;
      for (int i = 0; i < sent_frags; i++) begin
         order.push_back(i);
      end
      order.shuffle();
      if (sent_frags == 0) begin
         send_header(tag, 16'($urandom_range(0, 3)), 16'(tot), 16'($urandom_range(0, 4)));
      end
      foreach (order[i]) begin
         pick = $urandom_range(99);
         len = (pick < 90) ? $urandom_range(0, 6) : (pick < 95) ? FSIZE
             : $urandom_range(FSIZE + 1, 65535);
         send_header(tag, 16'(order[i]), 16'(tot), 16'(len));
         if (len <= FSIZE) begin
            send_bytes(($urandom_range(99) < 5) ? $urandom_range(0, len) : len);
            if ($urandom_range(99) < 10) begin
               send_bytes(1);
            end
         end
         if ($urandom_range(99) < 10) begin
            send_header(tag, 16'(order[i]), 16'(tot), 16'($urandom_range(0, 6)));
         end
         if ($urandom_range(99) < 15) begin
            send_request(KIND_BITMAP);
         end
         if ($urandom_range(99) < 10) begin
            send_request(3'($urandom));
         end
         if ($urandom_range(99) < 3) begin
            send_request(KIND_RESTART);
         end
         if (pause_midway && i == 0) begin
            drain();
         end
      end
      send_request(KIND_CRC);
      send_request(KIND_BITMAP);
   endtask

   task automatic test_random_traffic(int send_pct, int recv_pct, int item_goal);
      int goal;
      bit paused;
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      goal = items_sent + item_goal;
      paused = 1'b0;
      while (items_sent < goal) begin
         run_session(!paused);
         paused = 1'b1;
      end
      write_limit(6'($urandom_range(0, 63)));
   endtask

   initial begin
      #2_000_000;
      $display("simulation failed");
      $finish;
   end

   initial begin
      for (int i = 0; i < FRAGS; i++) begin
         frag_seen[i] = 1'b0;
      end
      close_tracker();
      store_ptr = 0;
      bitmap_limit = LIMIT_RESET;
      fail_count = 0;
      items_sent = 0;
      replies_seen = 0;
      limit_writes = 0;
      send_idle_pct = 26;
      recv_idle_pct = 77;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_header_cases();
      test_bitmap_limits();
      test_random_traffic(26, 77, 120);
      test_random_traffic(77, 26, 120);
      test_random_traffic(0, 0, 120);
      drain();
      $display("Sent %0d request beats and checked %0d reply beats,", items_sent, replies_seen);
      $display("with %0d bitmap limit writes across three idling mixes.", limit_writes);
      if (fail_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end
endmodule
`default_nettype wire

// ===== fragment_reassembly_tracker.f =====
+incdir+sv
sv/frt_pkg.sv
sv/frt_crc_unit.sv
sv/fragment_reassembly_tracker.sv
sim/fragment_reassembly_tracker_tb.sv
